// ===== sv/eskd_pkg.sv =====
// Shared types, constants and the function-key lookup for the escape key decoder.
package eskd_pkg;

    localparam int KEY_W     = 40;
    localparam int KEYS_W    = 3;
    localparam int MAX_KEYS  = 6;
    localparam int SEQ_LIMIT = 5;
    localparam int NUM_FKEYS = 22;

    localparam logic [7:0]  ESC_BYTE      = 8'h1B;
    localparam logic [7:0]  CSI_BYTE      = 8'h5B;
    localparam logic [15:0] CSI_PREFIX    = 16'h1B5B;
    localparam logic [7:0]  TIMEOUT_RESET = 8'd100;

    localparam logic [KEY_W-1:0] FKEY_CODES [NUM_FKEYS] = '{
        40'h00001B5B41, 40'h00001B5B42, 40'h00001B5B43, 40'h00001B5B44,
        40'h001B5B317E, 40'h001B5B327E, 40'h001B5B337E, 40'h001B5B347E,
        40'h001B5B357E, 40'h001B5B367E,
        40'h001B5B5B41, 40'h001B5B5B42, 40'h001B5B5B43, 40'h001B5B5B44,
        40'h001B5B5B45,
        40'h1B5B31377E, 40'h1B5B31387E, 40'h1B5B31397E, 40'h1B5B32307E,
        40'h1B5B32317E, 40'h1B5B32337E, 40'h1B5B32347E
    };

    // Source of the key loaded into the pending register.
    typedef enum logic [1:0] {
        SRC_HEAD,
        SRC_ESC,
        SRC_CODE
    } t_src;

    typedef struct packed {
        logic load_byte;
        logic tick_inc;
        logic clr_keys;
        logic emit;
        t_src emit_src;
        logic drop_scan;
        logic start_scan;
        logic scan_step;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_one;
        logic head_esc;
        logic second_csi;
        logic nkeys_max;
        logic tick_hit;
        logic scan_past;
        logic scan_match;
        logic scan_limit;
        logic pend_v;
        logic slot_free;
        logic can_emit;
    } t_dp_stat;

    function automatic logic is_fkey(input logic [KEY_W-1:0] code);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_FKEYS; i++) begin
            if (FKEY_CODES[i] == code) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ===== sv/escape_sequence_key_decoder_core.sv =====
// Top level of the escape-sequence key decoder: byte/tick stream in, key codes out.
// Each key is held in the pending register, then moves into the output register when
//   the next key of the beat replaces it; the last key of a beat moves out on flush.
// Input: a new beat is taken only once the sequencer is idle again, after walking the
//   held-byte queue one decision per cycle when output stalls allow; an unexpired tick leaves it idle.
// Reset: i_rst_n synchronous active low; empties the queue, clears the tick count
//   and output valid, and sets the timeout register to 100 ticks.
module escape_sequence_key_decoder_core #(
    parameter int HOLD_DEPTH = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Timeout register write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,     // escape_timeout_ticks
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] data_byte
    input  logic        i_s_tuser,      // [0] cmd: 0 byte, 1 tick
    // Key stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,      // [39:0] key_code
    output logic        o_m_tlast       // is_last of the input beat's keys
);
    import eskd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The timeout register is to be written only while idle (the user's duty, not enforced here), so take every beat.
    assign o_cfg_ready = 1'b1;

    // Sequencer: accepts a beat only when idle, then walks the queue head.
    eskd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_s_cmd   (i_s_tuser),
        .o_s_ready (o_s_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    // Datapath: held bytes, code builder, one pending key ahead of the output
    // register so the last key of a beat can be marked before it leaves.
    eskd_datapath #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_byte     (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_m_valid  (o_m_tvalid),
        .i_m_ready  (i_m_tready),
        .o_key      (o_m_tdata),
        .o_last     (o_m_tlast)
    );

endmodule

// ===== sv/eskd_datapath.sv =====
// Held-byte queue, code builder, tick counter, pending key and output register.
module eskd_datapath #(
    parameter int HOLD_DEPTH = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic [7:0]         i_byte,
    input  eskd_pkg::t_dp_cmd  i_cmd,
    output eskd_pkg::t_dp_stat o_stat,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    output logic [39:0]        o_key,
    output logic               o_last
);
    import eskd_pkg::*;

    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W = $clog2(HOLD_DEPTH);

    logic [7:0]       r_held [HOLD_DEPTH];
    logic [7:0]       n_held [HOLD_DEPTH];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_tick, n_tick;
    logic [7:0]       r_timeout, n_timeout;
    logic [KEY_W-1:0] r_code, n_code;
    logic [CNT_W-1:0] r_scan, n_scan;
    logic [KEY_W-1:0] r_pend, n_pend;
    logic             r_pend_v, n_pend_v;
    logic [KEYS_W-1:0] r_nkeys, n_nkeys;
    logic [KEY_W-1:0] r_out_key, n_out_key;
    logic             r_out_last, n_out_last;
    logic             r_out_v, n_out_v;

    logic [7:0]       w_scan_byte;
    logic [KEY_W-1:0] w_code_next;
    logic [KEY_W-1:0] w_key;
    logic [CNT_W-1:0] w_drop;
    logic             w_slot_free;

    assign w_scan_byte = r_held[r_scan[IDX_W-1:0]];
    assign w_code_next = {r_code[KEY_W-9:0], w_scan_byte};
    assign w_slot_free = !r_out_v || i_m_ready;
    assign w_drop      = i_cmd.drop_scan ? (r_scan + CNT_W'(1)) : CNT_W'(1);

    always_comb begin
        unique case (i_cmd.emit_src)
            SRC_HEAD: w_key = KEY_W'(r_held[0]);
            SRC_ESC:  w_key = KEY_W'(ESC_BYTE);
            SRC_CODE: w_key = w_code_next;
            default:  w_key = KEY_W'(ESC_BYTE);
        endcase
    end

    always_comb begin
        n_held     = r_held;
        n_cnt      = r_cnt;
        n_tick     = r_tick;
        n_timeout  = r_timeout;
        n_code     = r_code;
        n_scan     = r_scan;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_nkeys    = r_nkeys;
        n_out_key  = r_out_key;
        n_out_last = r_out_last;
        n_out_v    = r_out_v;

        if (r_out_v && i_m_ready) begin
            n_out_v = 1'b0;
        end
        if (i_cfg_we) begin
            n_timeout = i_cfg_data;
        end
        if (i_cmd.clr_keys) begin
            n_nkeys = '0;
        end
        // Append at the tail; a byte that finds the queue full is lost.
        if (i_cmd.load_byte && (r_cnt < CNT_W'(HOLD_DEPTH))) begin
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                if (r_cnt == CNT_W'(i)) begin
                    n_held[i] = i_byte;
                end
            end
            n_cnt = r_cnt + CNT_W'(1);
        end
        if (i_cmd.tick_inc) begin
            n_tick = r_tick + 8'd1;
        end
        if (i_cmd.start_scan) begin
            n_code = KEY_W'(CSI_PREFIX);
            n_scan = CNT_W'(2);
        end
        if (i_cmd.scan_step) begin
            n_code = w_code_next;
            n_scan = r_scan + CNT_W'(1);
        end
        // Push the previous pending key out, hold the new one, drop its bytes.
        if (i_cmd.emit) begin
            if (r_pend_v) begin
                n_out_key  = r_pend;
                n_out_last = 1'b0;
                n_out_v    = 1'b1;
            end
            n_pend   = w_key;
            n_pend_v = 1'b1;
            n_tick   = '0;
            n_nkeys  = n_nkeys + KEYS_W'(1);
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                for (int j = 1; i + j < HOLD_DEPTH; j++) begin
                    if (w_drop == CNT_W'(j)) begin
                        n_held[i] = r_held[i+j];
                    end
                end
            end
            n_cnt = r_cnt - w_drop;
        end
        if (i_cmd.flush) begin
            n_out_key  = r_pend;
            n_out_last = 1'b1;
            n_out_v    = 1'b1;
            n_pend_v   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held     <= n_held;
        r_code     <= n_code;
        r_scan     <= n_scan;
        r_pend     <= n_pend;
        r_out_key  <= n_out_key;
        r_out_last <= n_out_last;
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_tick    <= '0;
            r_timeout <= TIMEOUT_RESET;
            r_pend_v  <= 1'b0;
            r_nkeys   <= '0;
            r_out_v   <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_tick    <= n_tick;
            r_timeout <= n_timeout;
            r_pend_v  <= n_pend_v;
            r_nkeys   <= n_nkeys;
            r_out_v   <= n_out_v;
        end
    end

    always_comb begin
        o_stat.cnt_zero   = (r_cnt == '0);
        o_stat.cnt_one    = (r_cnt == CNT_W'(1));
        o_stat.head_esc   = (r_cnt != '0) && (r_held[0] == ESC_BYTE);
        o_stat.second_csi = (r_held[1] == CSI_BYTE);
        o_stat.nkeys_max  = (r_nkeys == KEYS_W'(MAX_KEYS));
        o_stat.tick_hit   = ((r_tick + 8'd1) == r_timeout);
        o_stat.scan_past  = (r_scan >= r_cnt);
        o_stat.scan_limit = (r_scan == CNT_W'(SEQ_LIMIT));
        o_stat.scan_match = (r_scan != CNT_W'(SEQ_LIMIT)) && is_fkey(w_code_next);
        o_stat.pend_v     = r_pend_v;
        o_stat.slot_free  = w_slot_free;
        o_stat.can_emit   = !r_pend_v || w_slot_free;
    end

    assign o_m_valid = r_out_v;
    assign o_key     = r_out_key;
    assign o_last    = r_out_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(HOLD_DEPTH))
        else $error("held byte count beyond queue depth");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_pend_v || w_slot_free))
        else $error("key emitted while pending key cannot move out");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_cnt != '0))
        else $error("key emitted from an empty queue");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> !r_pend_v)
        else $error("pending key left after flush");

    a_keys_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nkeys <= KEYS_W'(MAX_KEYS))
        else $error("too many keys for one input beat");

endmodule

// ===== sv/eskd_ctrl.sv =====
// Parse sequencer for the escape key decoder.
module eskd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    input  logic               i_s_cmd,
    output logic               o_s_ready,
    input  eskd_pkg::t_dp_stat i_stat,
    output eskd_pkg::t_dp_cmd  o_cmd
);
    import eskd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_HEAD  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    localparam logic CMD_BYTE = 1'b0;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '{emit_src: SRC_ESC, default: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    if (i_s_cmd == CMD_BYTE) begin
                        o_cmd.load_byte = 1'b1;
                        o_cmd.clr_keys  = 1'b1;
                        n_state         = ST_HEAD;
                    end else if (i_stat.head_esc) begin
                        if (i_stat.tick_hit) begin
                            o_cmd.clr_keys = 1'b1;
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_src = SRC_ESC;
                            n_state        = ST_HEAD;
                        end else begin
                            o_cmd.tick_inc = 1'b1;
                        end
                    end
                end
            end
            ST_HEAD: begin
                if (i_stat.cnt_zero || i_stat.nkeys_max) begin
                    n_state = ST_FLUSH;
                end else if (!i_stat.head_esc) begin
                    if (i_stat.can_emit) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_src = SRC_HEAD;
                    end
                end else if (i_stat.cnt_one) begin
                    n_state = ST_FLUSH;
                end else if (!i_stat.second_csi) begin
                    if (i_stat.can_emit) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_src = SRC_ESC;
                    end
                end else begin
                    o_cmd.start_scan = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_past) begin
                    n_state = ST_FLUSH;
                end else if (i_stat.scan_match) begin
                    if (i_stat.can_emit) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_src  = SRC_CODE;
                        o_cmd.drop_scan = 1'b1;
                        n_state         = ST_HEAD;
                    end
                end else if (i_stat.scan_limit) begin
                    if (i_stat.can_emit) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_src = SRC_ESC;
                        n_state        = ST_HEAD;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (!i_stat.pend_v) begin
                    n_state = ST_IDLE;
                end else if (i_stat.slot_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sim/escape_sequence_key_decoder_core_test.sv =====
// Self-checking stream testbench for the escape-sequence key decoder core.
`timescale 1ns / 1ps

module escape_sequence_key_decoder_core_test;
    import eskd_pkg::*;

    localparam int HOLD_DEPTH       = 6;
    localparam int SETTLE_CYCLES    = 48;    // worst key burst: 6 keys
    localparam int QUIET_LIMIT      = 2000;  // cycles with no beat on any channel
    localparam int RANDOM_PER_PHASE = 34;
    localparam int NUM_SETTINGS     = 5;
    localparam logic [7:0] FLUSH_BYTE = 8'h78;

    typedef enum logic {
        CMD_BYTE,
        CMD_TICK
    } t_cmd;

    typedef struct packed {
        logic [39:0] code;
        logic        last;
    } t_key_beat;

    // One row of the opening sequence; typed rows carry the single key they must emit.
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  data;
        logic        typed;
        logic [39:0] key;
    } t_opening_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [7:0]  i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic [7:0]  i_s_tdata   = '0;
    logic        i_s_tuser   = 1'b0;
    logic        i_m_tready  = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;
    logic        o_m_tlast;

    // Function-key codes recognized after ESC [, kept apart from the design's own table.
    logic [39:0] known_keys [22] = '{
        40'h1B5B41, 40'h1B5B42, 40'h1B5B43, 40'h1B5B44,
        40'h1B5B317E, 40'h1B5B327E, 40'h1B5B337E, 40'h1B5B347E,
        40'h1B5B357E, 40'h1B5B367E,
        40'h1B5B5B41, 40'h1B5B5B42, 40'h1B5B5B43, 40'h1B5B5B44, 40'h1B5B5B45,
        40'h1B5B31377E, 40'h1B5B31387E, 40'h1B5B31397E, 40'h1B5B32307E,
        40'h1B5B32317E, 40'h1B5B32337E, 40'h1B5B32347E
    };

    // Bytes that often follow ESC [ in real traffic: prefixes, terminators, letters.
    logic [7:0] csi_tail [12] = '{
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h37, 8'h39, 8'h30,
        8'h7E, 8'h5B, 8'h41, 8'h45
    };

    // Opening sequence: byte extremes, idle tick, cursor key, double-bracket key,
    // longest key, ESC ESC, six bytes with no match (six keys from one beat),
    // and a held ESC [ 3 that the reset timeout must release.
    t_opening_row opening_rows [27] = '{
        '{CMD_BYTE, 8'h41,     1'b1, 40'h41},
        '{CMD_BYTE, 8'h00,     1'b1, 40'h00},
        '{CMD_BYTE, 8'hFF,     1'b1, 40'hFF},
        '{CMD_TICK, 8'h00,     1'b0, 40'h0},
        '{CMD_BYTE, ESC_BYTE,  1'b0, 40'h0},
        '{CMD_TICK, 8'h00,     1'b0, 40'h0},
        '{CMD_BYTE, CSI_BYTE,  1'b0, 40'h0},
        '{CMD_BYTE, 8'h41,     1'b1, 40'h1B5B41},
        '{CMD_BYTE, ESC_BYTE,  1'b0, 40'h0},
        '{CMD_BYTE, CSI_BYTE,  1'b0, 40'h0},
        '{CMD_BYTE, CSI_BYTE,  1'b0, 40'h0},
        '{CMD_BYTE, 8'h45,     1'b1, 40'h1B5B5B45},
        '{CMD_BYTE, ESC_BYTE,  1'b0, 40'h0},
        '{CMD_BYTE, CSI_BYTE,  1'b0, 40'h0},
        '{CMD_BYTE, 8'h32,     1'b0, 40'h0},
        '{CMD_BYTE, 8'h34,     1'b0, 40'h0},
        '{CMD_BYTE, 8'h7E,     1'b1, 40'h1B5B32347E},
        '{CMD_BYTE, ESC_BYTE,  1'b0, 40'h0},
        '{CMD_BYTE, ESC_BYTE,  1'b0, 40'h0},
        '{CMD_BYTE, CSI_BYTE,  1'b0, 40'h0},
        '{CMD_BYTE, 8'h39,     1'b0, 40'h0},
        '{CMD_BYTE, 8'h39,     1'b0, 40'h0},
        '{CMD_BYTE, 8'h39,     1'b0, 40'h0},
        '{CMD_BYTE, 8'h39,     1'b0, 40'h0},
        '{CMD_BYTE, ESC_BYTE,  1'b0, 40'h0},
        '{CMD_BYTE, CSI_BYTE,  1'b0, 40'h0},
        '{CMD_BYTE, 8'h33,     1'b0, 40'h0}
    };

    // Shadow of the decoder state.
    logic [7:0] hold [HOLD_DEPTH];
    int         hold_fill   = 0;
    logic [7:0] esc_ticks   = '0;
    logic [7:0] esc_timeout = TIMEOUT_RESET;

    t_key_beat step_keys [$];   // keys caused by the beat being predicted
    t_key_beat keys_due  [$];   // keys predicted but not yet seen on the key stream

    bit rush    = 1'b0;         // no idling on either side while set
    int rx_hold = 0;

    int beats_in      = 0;
    int ticks_in      = 0;
    int keys_out      = 0;
    int timeouts_seen = 0;
    int cfg_writes    = 0;
    int fail_count    = 0;
    int quiet         = 0;

    escape_sequence_key_decoder_core #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic is_known_key(input logic [47:0] code);
        logic hit;
        hit = 1'b0;
        foreach (known_keys[i]) begin
            if ({8'h00, known_keys[i]} == code) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Record one key for the current beat; any key restarts the escape tick count.
    task automatic queue_key(input logic [39:0] code);
        t_key_beat k;
        if (step_keys.size() < MAX_KEYS) begin
            k.code = code;
            k.last = 1'b0;
            step_keys.push_back(k);
            esc_ticks = '0;
        end
    endtask

    task automatic drop_held(input int n);
        if (n >= hold_fill) begin
            hold_fill = 0;
        end else begin
            for (int i = 0; i < hold_fill - n; i++) begin
                hold[i] = hold[i + n];
            end
            hold_fill = hold_fill - n;
        end
    endtask

    // Walk the held bytes until the head needs more input or six keys are out.
    task automatic rescan_hold();
        logic [47:0] code;
        bit          done;
        bit          waiting;
        waiting = 1'b0;
        while (hold_fill > 0 && step_keys.size() < MAX_KEYS && !waiting) begin
            if (hold[0] != ESC_BYTE) begin
                queue_key({32'h0, hold[0]});
                drop_held(1);
            end else if (hold_fill == 1) begin
                waiting = 1'b1;
            end else if (hold[1] != CSI_BYTE) begin
                queue_key({32'h0, ESC_BYTE});
                drop_held(1);
            end else begin
                // Grow the code one byte at a time behind ESC [.
                code = {32'h0, CSI_PREFIX};
                done = 1'b0;
                for (int n = 2; n < hold_fill && n < HOLD_DEPTH && !done; n++) begin
                    code = {code[39:0], hold[n]};
                    if (is_known_key(code)) begin
                        queue_key(code[39:0]);
                        drop_held(n + 1);
                        done = 1'b1;
                    end else if (n + 1 > SEQ_LIMIT) begin
                        // Too long for any key: give up on the ESC alone.
                        queue_key({32'h0, ESC_BYTE});
                        drop_held(1);
                        done = 1'b1;
                    end
                end
                waiting = !done;
            end
        end
    endtask

    // Work out the keys caused by one accepted beat and queue them for checking.
    task automatic predict_keys(input t_cmd cmd, input logic [7:0] data);
        t_key_beat tail;
        step_keys.delete();
        if (cmd == CMD_BYTE) begin
            if (hold_fill < HOLD_DEPTH) begin
                hold[hold_fill] = data;
                hold_fill++;
            end
            rescan_hold();
        end else if (hold_fill > 0 && hold[0] == ESC_BYTE) begin
            esc_ticks = esc_ticks + 8'd1;
            if (esc_ticks == esc_timeout) begin
                timeouts_seen++;
                queue_key({32'h0, ESC_BYTE});
                drop_held(1);
                rescan_hold();
            end
        end
        if (step_keys.size() > 0) begin
            tail = step_keys.pop_back();
            tail.last = 1'b1;
            step_keys.push_back(tail);
        end
        while (step_keys.size() > 0) begin
            keys_due.push_back(step_keys.pop_front());
        end
    endtask

    // ------------------------------------------------------------------ drivers

    // Present one beat after a random gap, hold it until taken, then predict.
    task automatic send_beat(input t_cmd cmd, input logic [7:0] data);
        int gap;
        gap = rush ? 0 : $urandom_range(0, 17);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= data;
        do @(posedge i_clk); while (!o_s_tready);
        beats_in++;
        if (cmd == CMD_TICK) begin
            ticks_in++;
        end
        predict_keys(cmd, data);
    endtask

    // Flush held bytes with a plain filler, drain every key, then let the
    // sequencer finish any scan that emits nothing.
    task automatic quiesce();
        while (hold_fill > 0) begin
            send_beat(CMD_BYTE, FLUSH_BYTE);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (keys_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [7:0] value);
        quiesce();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        esc_timeout = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] tail_byte();
        if ($urandom_range(0, 1) == 0) begin
            return csi_tail[$urandom_range(0, 11)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed key sequences with random content, plus noise:
    // stray bytes, ESC with a non-bracket, broken ESC [ runs, timeouts, idle ticks.
    task automatic random_burst(input int budget);
        int          first;
        int          kind;
        int          len;
        logic [39:0] code;
        first = beats_in;
        while (beats_in - first < budget) begin
            rush = ($urandom_range(0, 6) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                code = known_keys[$urandom_range(0, 21)];
                len  = (code[39:32] != 0) ? 3 : ((code[31:24] != 0) ? 2 : 1);
                send_beat(CMD_BYTE, ESC_BYTE);
                send_beat(CMD_BYTE, CSI_BYTE);
                for (int i = len - 1; i >= 0; i--) begin
                    send_beat(CMD_BYTE, code[8*i +: 8]);
                end
            end else if (kind < 55) begin
                send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
            end else if (kind < 65) begin
                send_beat(CMD_BYTE, ESC_BYTE);
                send_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
            end else if (kind < 80) begin
                send_beat(CMD_BYTE, ESC_BYTE);
                send_beat(CMD_BYTE, CSI_BYTE);
                repeat ($urandom_range(1, 4)) send_beat(CMD_BYTE, tail_byte());
            end else if (kind < 90) begin
                // Leave an ESC waiting, then tick it out when the setting allows.
                send_beat(CMD_BYTE, ESC_BYTE);
                if ($urandom_range(0, 1) == 1) begin
                    send_beat(CMD_BYTE, CSI_BYTE);
                    repeat ($urandom_range(0, 2)) send_beat(CMD_BYTE, tail_byte());
                end
                len = (esc_timeout <= 16) ? int'(esc_timeout) : $urandom_range(1, 4);
                repeat (len) send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 3)) send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
            end
        end
        rush = 1'b0;
    endtask

    // ---------------------------------------------------------- key stream side

    // Hold ready low for the stall drawn at the last accepted key.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            i_m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Compare every accepted key beat with the oldest prediction.
    always @(posedge i_clk) begin : key_check
        t_key_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            keys_out++;
            rx_hold = rush ? 0 : $urandom_range(0, 17);
            if (keys_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("key %0d: nothing expected, got code %h last %b",
                             keys_out, o_m_tdata, o_m_tlast);
                end
            end else begin
                want = keys_due.pop_front();
                if (o_m_tdata !== want.code || o_m_tlast !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("key %0d: expected code %h last %b, got code %h last %b",
                                 keys_out, want.code, want.last, o_m_tdata, o_m_tlast);
                    end
                end
            end
        end
    end

    // End the run if no channel moves a beat for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d keys outstanding",
                     quiet, keys_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // --------------------------------------------------------------- main flow

    initial begin : run
        logic [7:0] settings [NUM_SETTINGS];
        t_key_beat  typed_key;
        settings = '{8'd1, 8'd255, 8'd4, 8'($urandom_range(2, 16)),
                     8'($urandom_range(1, 255))};

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Opening sequence at the reset timeout; swap in hand-written keys where typed.
        foreach (opening_rows[r]) begin
            send_beat(opening_rows[r].cmd, opening_rows[r].data);
            if (opening_rows[r].typed) begin
                void'(keys_due.pop_back());
                typed_key.code = opening_rows[r].key;
                typed_key.last = 1'b1;
                keys_due.push_back(typed_key);
            end
        end
        // Release the held ESC [ 3 through the reset timeout.
        repeat (TIMEOUT_RESET) send_beat(CMD_TICK, 8'($urandom_range(0, 255)));

        foreach (settings[p]) begin
            write_timeout(settings[p]);
            random_burst(RANDOM_PER_PHASE);
        end

        quiesce();

        $display("covered %0d input beats (%0d ticks) and %0d keys over %0d timeout writes",
                 beats_in, ticks_in, keys_out, cfg_writes);
        $display("escape timeouts expired: %0d, failures: %0d", timeouts_seen, fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
